// File: rtl/mtt_pkg.sv
// shared types, constants and character class helpers for the text tokenizer
// no dependencies
package mtt_pkg;

    // result event codes
    localparam logic [3:0] EV_TEXT   = 4'd0;
    localparam logic [3:0] EV_STREND = 4'd4;
    localparam logic [3:0] EV_LBRACE = 4'd5;
    localparam logic [3:0] EV_RBRACE = 4'd6;
    localparam logic [3:0] EV_LPAREN = 4'd7;
    localparam logic [3:0] EV_RPAREN = 4'd8;
    localparam logic [3:0] EV_ERROR  = 4'd9;
    localparam logic [3:0] EV_END    = 4'd10;
    localparam logic [3:0] EV_NONE   = 4'd0;

    // token kinds, which double as the kind end event
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_INT   = 2'd1;
    localparam logic [1:0] KIND_FLOAT = 2'd2;
    localparam logic [1:0] KIND_KEY   = 2'd3;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // one or two results produced by one accepted item
    typedef struct packed {
        logic       two;
        logic [3:0] ev0;
        logic [7:0] b0;
        logic [3:0] ev1;
        logic [7:0] b1;
    } cmd_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // zero when not a bracket
    function automatic logic [3:0] bracket_event(input logic [7:0] c);
        logic [3:0] ev;
        ev = EV_NONE;
        if (c == CH_LBRACE) ev = EV_LBRACE;
        if (c == CH_RBRACE) ev = EV_RBRACE;
        if (c == CH_LPAREN) ev = EV_LPAREN;
        if (c == CH_RPAREN) ev = EV_RPAREN;
        return ev;
    endfunction

endpackage

// File: rtl/mtt_front.sv
// front end: lexer state and per-character classification into result commands
// depends on mtt_pkg
module mtt_front
    import mtt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] char_in,
    input  logic       end_of_input,
    output logic       push,
    output cmd_t       cmd
);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_TOKEN   = 3'd1;
    localparam logic [2:0] MODE_STRING  = 3'd2;
    localparam logic [2:0] MODE_SLASH   = 3'd3;
    localparam logic [2:0] MODE_COMMENT = 3'd4;

    logic [2:0] mode_reg, mode_next;
    logic [1:0] kind_reg, kind_next;
    logic       err_reg, err_next;
    logic [1:0] cnt;
    logic [3:0] br;
    logic [3:0] kind_ev;

    assign br      = bracket_event(char_in);
    assign kind_ev = {2'b00, kind_reg};

    always_comb begin
        mode_next = mode_reg;
        kind_next = kind_reg;
        err_next  = err_reg;
        cnt       = 2'd0;
        cmd.two   = 1'b0;
        cmd.ev0   = EV_NONE;
        cmd.b0    = 8'h00;
        cmd.ev1   = EV_NONE;
        cmd.b1    = 8'h00;
        if (end_of_input) begin
            cnt = 2'd1;
            cmd.ev0 = EV_END;
            if (!err_reg && (mode_reg == MODE_TOKEN)) begin
                cnt = 2'd2;
                cmd.ev0 = kind_ev;
                cmd.ev1 = EV_END;
            end else if (!err_reg && ((mode_reg == MODE_STRING) ||
                                      (mode_reg == MODE_SLASH))) begin
                cnt = 2'd2;
                cmd.ev0 = EV_ERROR;
                cmd.ev1 = EV_END;
            end
            mode_next = MODE_IDLE;
            kind_next = KIND_NONE;
            err_next  = 1'b0;
        end else if (!err_reg) begin
            unique case (mode_reg)
                MODE_TOKEN: begin
                    if (br != EV_NONE) begin
                        cnt = 2'd2;
                        cmd.ev0 = kind_ev;
                        cmd.ev1 = br;
                        cmd.b1  = char_in;
                        mode_next = MODE_IDLE;
                        kind_next = KIND_NONE;
                    end else if (is_space(char_in) || (char_in == CH_QUOTE) ||
                                 (char_in == CH_SLASH)) begin
                        cnt = 2'd1;
                        cmd.ev0 = kind_ev;
                        kind_next = KIND_NONE;
                        if (char_in == CH_QUOTE) mode_next = MODE_STRING;
                        else if (char_in == CH_SLASH) mode_next = MODE_SLASH;
                        else mode_next = MODE_IDLE;
                    end else if (is_digit(char_in) ||
                                 (is_letter(char_in) && (kind_reg == KIND_KEY))) begin
                        cnt = 2'd1;
                        cmd.ev0 = EV_TEXT;
                        cmd.b0  = char_in;
                    end else if ((char_in == CH_DOT) && (kind_reg == KIND_INT)) begin
                        cnt = 2'd1;
                        cmd.ev0 = EV_TEXT;
                        cmd.b0  = char_in;
                        kind_next = KIND_FLOAT;
                    end else if ((char_in == CH_MINUS) || is_letter(char_in) ||
                                 (char_in == CH_DOT)) begin
                        cnt = 2'd1;
                        cmd.ev0 = EV_ERROR;
                        err_next  = 1'b1;
                        mode_next = MODE_IDLE;
                        kind_next = KIND_NONE;
                    end
                    // anything else inside a token is dropped
                end
                MODE_STRING: begin
                    cnt = 2'd1;
                    if (char_in == CH_QUOTE) begin
                        cmd.ev0 = EV_STREND;
                        mode_next = MODE_IDLE;
                    end else begin
                        cmd.ev0 = EV_TEXT;
                        cmd.b0  = char_in;
                    end
                end
                MODE_SLASH: begin
                    if (char_in == CH_SLASH) begin
                        mode_next = MODE_COMMENT;
                    end else begin
                        cnt = 2'd1;
                        cmd.ev0 = EV_ERROR;
                        err_next  = 1'b1;
                        mode_next = MODE_IDLE;
                        kind_next = KIND_NONE;
                    end
                end
                MODE_COMMENT: begin
                    if (char_in == CH_LF) mode_next = MODE_IDLE;
                end
                default: begin
                    mode_next = MODE_IDLE;
                    if (is_space(char_in)) begin
                        cnt = 2'd0;
                    end else if (br != EV_NONE) begin
                        cnt = 2'd1;
                        cmd.ev0 = br;
                        cmd.b0  = char_in;
                    end else if (is_digit(char_in) || (char_in == CH_MINUS)) begin
                        cnt = 2'd1;
                        cmd.ev0 = EV_TEXT;
                        cmd.b0  = char_in;
                        mode_next = MODE_TOKEN;
                        kind_next = KIND_INT;
                    end else if (is_letter(char_in)) begin
                        cnt = 2'd1;
                        cmd.ev0 = EV_TEXT;
                        cmd.b0  = char_in;
                        mode_next = MODE_TOKEN;
                        kind_next = KIND_KEY;
                    end else if (char_in == CH_QUOTE) begin
                        mode_next = MODE_STRING;
                    end else if (char_in == CH_SLASH) begin
                        mode_next = MODE_SLASH;
                    end else begin
                        cnt = 2'd1;
                        cmd.ev0 = EV_ERROR;
                        err_next  = 1'b1;
                        kind_next = KIND_NONE;
                    end
                end
            endcase
        end
        cmd.two = (cnt == 2'd2);
    end

    assign push = accept && (cnt != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            kind_reg <= KIND_NONE;
            err_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            kind_reg <= kind_next;
            err_reg  <= err_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a held error always leaves the lexer parked in idle with no token
    a_err_parks: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> (mode_reg == MODE_IDLE) && (kind_reg == KIND_NONE))
        else $error("error held with lexer not parked");
    // a token in progress always has a kind
    a_token_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_TOKEN) |-> (kind_reg != KIND_NONE))
        else $error("token mode without a kind");
`endif

endmodule

// File: rtl/mtt_fifo.sv
// short command queue between front and back end
// depends on mtt_pkg
module mtt_fifo
    import mtt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic not_empty,
    output logic full
);

    cmd_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     cnt_reg;

    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head_cmd  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("command queue overflow");
`endif

endmodule

// File: rtl/mtt_back.sv
// back end: plays each queued command out as one or two result items
// depends on mtt_pkg
module mtt_back
    import mtt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        head_cmd,
    input  logic        not_empty,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [3:0]  m_tuser,
    output logic        m_tlast
);

    cmd_t cur_reg;
    logic valid_reg;
    logic phase_reg;
    logic last_phase;
    logic [3:0] ev;
    logic [7:0] byte_out;

    assign last_phase = (phase_reg == cur_reg.two);
    assign ev         = phase_reg ? cur_reg.ev1 : cur_reg.ev0;
    assign byte_out   = phase_reg ? cur_reg.b1  : cur_reg.b0;

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_out;
    assign m_tuser  = ev;
    assign m_tlast  = last_phase;

    // reload from the queue when idle or once the final result of this command goes
    assign pop = not_empty && (!valid_reg || (m_tready && last_phase));

    always_ff @(posedge aclk) begin
        if (pop) cur_reg <= head_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
            phase_reg <= 1'b0;
        end else if (valid_reg && m_tready) begin
            if (last_phase) begin
                valid_reg <= 1'b0;
                phase_reg <= 1'b0;
            end else begin
                phase_reg <= 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_two: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (valid_reg && cur_reg.two))
        else $error("second result of a single-result command");
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == EV_END)) |-> m_tlast)
        else $error("end event not marked last");
`endif

endmodule

// File: rtl/model_text_tokenizer_unit.sv
// top level of the streaming text tokenizer
// depends on mtt_pkg, mtt_front, mtt_fifo, mtt_back
//
// One character is taken per clock while the queue has room; the lexer decides
// every character in the cycle it is accepted and queues the one or two results
// that it causes, if any, as one entry of a four-entry command queue, so input
// keeps flowing while results wait on the output. The output side delivers one
// result per cycle while m_tready is high; a character that causes two results
// (a token closed by a bracket, or end of input with a token, string or lone
// slash pending) holds the output for both, so long runs of those limit the
// sustained input rate. Input stalls only when the queue is full.
module model_text_tokenizer_unit
    import mtt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] text_byte
    output logic [3:0]  m_tuser,   // [3:0] event_res
    output logic        m_tlast    // last
);

    logic accept;
    logic push;
    logic pop;
    logic not_empty;
    logic full;
    cmd_t push_cmd;
    cmd_t head_cmd;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    mtt_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .char_in      (s_tdata),
        .end_of_input (s_tlast),
        .push         (push),
        .cmd          (push_cmd)
    );

    mtt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (not_empty),
        .full      (full)
    );

    mtt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_cmd  (head_cmd),
        .not_empty (not_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: tb/tokenizer_event_checker.sv
// watches both channels of the text tokenizer, predicts its events and compares them
// depends on mtt_pkg for the event, kind and character codes
module tokenizer_event_checker
    import mtt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // end_of_input
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] text_byte
    input  logic [3:0]  m_tuser,   // [3:0] event_res
    input  logic        m_tlast,   // last
    output int          mismatch_count,
    output int          events_awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        LEX_IDLE,
        LEX_WORD,
        LEX_QUOTED,
        LEX_SLASH,
        LEX_COMMENT
    } lex_mode_t;

    typedef struct packed {
        logic [3:0] ev;
        logic [7:0] text;
        logic       last;
    } tok_event_t;

    lex_mode_t  lex_mode;
    logic [1:0] word_kind;
    logic       err_latched;

    tok_event_t expected_events[$];
    tok_event_t item_events[$];

    initial begin
        mismatch_count = 0;
        events_awaited = 0;
        lex_mode       = LEX_IDLE;
        word_kind      = KIND_NONE;
        err_latched    = 1'b0;
    end

    function automatic bit is_blank(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_CR, CH_LF: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // ascii letters only, high bytes are no class at all
    function automatic bit is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic [3:0] brace_code(input logic [7:0] c);
        case (c)
            CH_LBRACE: return EV_LBRACE;
            CH_RBRACE: return EV_RBRACE;
            CH_LPAREN: return EV_LPAREN;
            CH_RPAREN: return EV_RPAREN;
            default:   return EV_NONE;
        endcase
    endfunction

    task automatic reset_lexer();
        lex_mode    = LEX_IDLE;
        word_kind   = KIND_NONE;
        err_latched = 1'b0;
    endtask

    task automatic post(input logic [3:0] ev, input logic [7:0] b);
        tok_event_t e;
        e.ev   = ev;
        e.text = b;
        e.last = 1'b0;
        item_events.insert(item_events.size(), e);
    endtask

    task automatic flag_error();
        post(EV_ERROR, 8'h00);
        err_latched = 1'b1;
        lex_mode    = LEX_IDLE;
        word_kind   = KIND_NONE;
    endtask

    task automatic close_word(input lex_mode_t next_mode);
        post({2'b00, word_kind}, 8'h00);
        word_kind = KIND_NONE;
        lex_mode  = next_mode;
    endtask

    task automatic lex_idle(input logic [7:0] c);
        logic [3:0] br;
        br = brace_code(c);
        if (!is_blank(c)) begin
            if (br != EV_NONE) begin
                post(br, c);
            end else if (is_num(c) || c == CH_MINUS) begin
                lex_mode  = LEX_WORD;
                word_kind = KIND_INT;
                post(EV_TEXT, c);
            end else if (is_alpha(c)) begin
                lex_mode  = LEX_WORD;
                word_kind = KIND_KEY;
                post(EV_TEXT, c);
            end else if (c == CH_QUOTE) begin
                lex_mode = LEX_QUOTED;
            end else if (c == CH_SLASH) begin
                lex_mode = LEX_SLASH;
            end else begin
                flag_error();
            end
        end
    endtask

    task automatic lex_word(input logic [7:0] c);
        logic [3:0] br;
        br = brace_code(c);
        if (br != EV_NONE) begin
            close_word(LEX_IDLE);
            post(br, c);
        end else if (is_blank(c)) begin
            close_word(LEX_IDLE);
        end else if (c == CH_QUOTE) begin
            close_word(LEX_QUOTED);
        end else if (c == CH_SLASH) begin
            close_word(LEX_SLASH);
        end else if (is_num(c)) begin
            post(EV_TEXT, c);
        end else if (c == CH_MINUS) begin
            flag_error();
        end else if (is_alpha(c)) begin
            if (word_kind == KIND_KEY) post(EV_TEXT, c);
            else flag_error();
        end else if (c == CH_DOT) begin
            if (word_kind == KIND_INT) begin
                word_kind = KIND_FLOAT;
                post(EV_TEXT, c);
            end else begin
                flag_error();
            end
        end
        // anything else inside a word is silently dropped
    endtask

    task automatic lex_item(input logic [7:0] c, input logic eoi);
        item_events.delete();
        if (eoi) begin
            if (!err_latched) begin
                if (lex_mode == LEX_WORD) post({2'b00, word_kind}, 8'h00);
                else if (lex_mode == LEX_QUOTED || lex_mode == LEX_SLASH) post(EV_ERROR, 8'h00);
            end
            post(EV_END, 8'h00);
            reset_lexer();
        end else if (!err_latched) begin
            case (lex_mode)
                LEX_WORD: begin
                    lex_word(c);
                end
                LEX_QUOTED: begin
                    if (c == CH_QUOTE) begin
                        post(EV_STREND, 8'h00);
                        lex_mode = LEX_IDLE;
                    end else begin
                        post(EV_TEXT, c);
                    end
                end
                LEX_SLASH: begin
                    if (c == CH_SLASH) lex_mode = LEX_COMMENT;
                    else flag_error();
                end
                LEX_COMMENT: begin
                    if (c == CH_LF) lex_mode = LEX_IDLE;
                end
                default: begin
                    lex_mode = LEX_IDLE;
                    lex_idle(c);
                end
            endcase
        end
        if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
        foreach (item_events[i]) expected_events.insert(expected_events.size(), item_events[i]);
    endtask

    always @(posedge aclk) begin
        tok_event_t want;
        if (!aresetn) begin
            reset_lexer();
            expected_events.delete();
        end else begin
            if (s_tvalid && s_tready) lex_item(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected event: event_res %0d text_byte %h last %b",
                           m_tuser, m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (m_tuser !== want.ev) begin
                        $error("event_res: expected %0d, got %0d", want.ev, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata !== want.text) begin
                        $error("text_byte: expected %h, got %h", want.text, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
        events_awaited = expected_events.size();
    end

endmodule

// File: tb/tb_model_text_tokenizer_unit.sv
// top of the text tokenizer testbench: clock, reset, character stimulus and verdict
// depends on mtt_pkg, model_text_tokenizer_unit and tokenizer_event_checker
module tb_model_text_tokenizer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mtt_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 290;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } char_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    int fail_total;
    int events_pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    char_item_t text_q[$];

    model_text_tokenizer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tokenizer_event_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (fail_total),
        .events_awaited (events_pending)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ends the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** model_text_tokenizer_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] rand_bracket();
        case ($urandom_range(3))
            0:       return CH_LBRACE;
            1:       return CH_RBRACE;
            2:       return CH_LPAREN;
            default: return CH_RPAREN;
        endcase
    endfunction

    // bytes of no class: dropped inside a word, invalid between words
    function automatic logic [7:0] rand_stray();
        case ($urandom_range(4))
            0:       return "#";
            1:       return ",";
            2:       return ";";
            3:       return 8'h00;
            default: return 8'h80 | 8'($urandom_range(127));
        endcase
    endfunction

    task automatic put_item(input logic [7:0] c, input logic eoi);
        char_item_t it;
        it.ch  = c;
        it.eoi = eoi;
        text_q.insert(text_q.size(), it);
    endtask

    task automatic put_char(input logic [7:0] c);
        put_item(c, 1'b0);
    endtask

    task automatic put_end();
        put_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic end_word();
        case ($urandom_range(7))
            0, 1, 2, 3: put_char(rand_blank());
            4, 5:       put_char(rand_bracket());
            6:          ;
            default: begin
                // slash closes the word and opens a comment
                put_char(CH_SLASH);
                put_char(CH_SLASH);
                put_char(CH_LF);
            end
        endcase
    endtask

    task automatic build_phrase();
        int n;
        logic [7:0] b;
        case ($urandom_range(18))
            0, 1, 2: begin
                if ($urandom_range(3) == 0) put_char(CH_MINUS);
                repeat ($urandom_range(1, 5)) put_char(rand_digit());
                if ($urandom_range(5) == 0) begin
                    put_char(rand_stray());
                    put_char(rand_digit());
                end
                end_word();
            end
            3, 4: begin
                repeat ($urandom_range(1, 3)) put_char(rand_digit());
                put_char(CH_DOT);
                repeat ($urandom_range(0, 3)) put_char(rand_digit());
                end_word();
            end
            5, 6, 7: begin
                put_char(rand_letter());
                n = $urandom_range(0, 6);
                repeat (n) put_char($urandom_range(3) == 0 ? rand_digit() : rand_letter());
                if ($urandom_range(7) == 0) put_char(rand_stray());
                end_word();
            end
            8, 9: begin
                put_char(CH_QUOTE);
                repeat ($urandom_range(0, 6)) begin
                    do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
                    put_char(b);
                end
                put_char(CH_QUOTE);
            end
            10: begin
                put_char(CH_SLASH);
                put_char(CH_SLASH);
                repeat ($urandom_range(0, 6)) begin
                    do b = 8'($urandom_range(255)); while (b == CH_LF);
                    put_char(b);
                end
                put_char(CH_LF);
            end
            11, 12: repeat ($urandom_range(1, 3)) put_char(rand_bracket());
            13, 14: repeat ($urandom_range(1, 3)) put_char(rand_blank());
            15: put_end();
            16: begin
                // malformed input, followed by bytes the held error swallows
                case ($urandom_range(5))
                    0: put_char(CH_DOT);
                    1: begin
                        put_char(rand_digit());
                        put_char(rand_letter());
                    end
                    2: begin
                        put_char(rand_digit());
                        put_char(CH_DOT);
                        put_char(CH_DOT);
                    end
                    3: begin
                        put_char(rand_letter());
                        put_char($urandom_range(1) ? CH_MINUS : CH_DOT);
                    end
                    4: begin
                        put_char(CH_SLASH);
                        put_char(rand_letter());
                    end
                    default: put_char(rand_stray());
                endcase
                repeat ($urandom_range(2)) put_char(8'($urandom_range(255)));
                put_end();
            end
            17: begin
                repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(255)));
                if ($urandom_range(1)) put_end();
            end
            default: begin
                // text cut off by end of input
                case ($urandom_range(2))
                    0: begin
                        put_char(CH_QUOTE);
                        repeat ($urandom_range(0, 3)) begin
                            do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
                            put_char(b);
                        end
                    end
                    1: put_char(CH_SLASH);
                    default: put_char($urandom_range(1) ? rand_digit() : rand_letter());
                endcase
                put_end();
            end
        endcase
    endtask

    task automatic send_char(input logic [7:0] c, input logic eoi);
        int gap;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(255));
            s_tlast  <= 1'($urandom_range(1));
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_queued(inout int sent);
        char_item_t it;
        while (text_q.size() > 0) begin
            it = text_q.pop_front();
            send_char(it.ch, it.eoi);
            sent++;
        end
    endtask

    initial begin
        int sent;
        int phase;
        sent = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed opening: comment after a word, dropped bytes, held error, strings,
        // float closed by a brace, end of input in a token, string, slash or error
        put_char("7");
        put_char(CH_SLASH);
        put_char(CH_SLASH);
        put_char(8'hFF);
        put_char(CH_LF);
        put_char("a");
        put_char(8'h80);
        put_char(CH_DOT);
        put_char("x");
        put_item(8'hFF, 1'b1);
        put_char(CH_MINUS);
        put_char(CH_DOT);
        put_char("9");
        put_char(CH_LBRACE);
        put_char(CH_QUOTE);
        put_char(CH_LF);
        put_char(8'h00);
        put_char(CH_QUOTE);
        put_char("q");
        put_char(CH_QUOTE);
        put_item(8'h00, 1'b1);
        put_char(CH_SLASH);
        put_item(8'h00, 1'b1);
        put_char("5");
        put_item(8'h00, 1'b1);
        put_char(8'h00);
        put_item(8'h00, 1'b1);
        send_queued(sent);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_phrase();
                send_queued(sent);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (events_pending != 0) @(negedge aclk);
        // room for any stray events still in the output queue
        repeat (24) @(negedge aclk);

        if (fail_total == 0) begin
            $display("** model_text_tokenizer_unit: PASSED **");
        end else begin
            $display("** model_text_tokenizer_unit: FAILED **");
        end
        $finish;
    end

endmodule
